### src/assert_macros.svh
// Assertion macros for the RTL files; alpha_over_blend includes them.
// Include by bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is active (reset is active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/aob_pkg.sv
// Constants and types for the source-over alpha blender.
// No dependencies; imported by alpha_over_blend.
package aob_pkg;

    localparam int CH_W    = 8;            // bits per color or alpha channel
    localparam int SUM_W   = 16;           // weight sum S, at most 255*255
    localparam int PROD_W  = 24;           // channel times weight
    localparam int NUM_W   = 25;           // numerator, sum of two products
    localparam int COLORS  = 3;            // red, green, blue
    localparam int LANES   = 4;            // three colors plus alpha
    localparam int STAGES  = 3 + CH_W;     // weights, products, numerator, divide steps
    localparam int IN_W    = 8 * CH_W;
    localparam int OUT_W   = LANES * CH_W;

    localparam logic [CH_W-1:0]  CH_MAX  = 8'd255;
    localparam logic [SUM_W-1:0] ONE_DIV = 16'd1;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [NUM_W-1:0]  num_t;

endpackage

### src/alpha_over_blend.sv
// Source-over alpha blender: one RGBA pixel out for each front/back pixel pair.
// Depends on aob_pkg and assert_macros.svh.
//
// The block takes one pixel pair per clock and returns one blended pixel per
// clock while the output is not stalled.
// The first three stages form the weights fa*255 and ba*(255-fa), the two
// channel products and the numerator; the output alpha S/255 is formed in the
// numerator stage by a shift-and-add reciprocal and then rides along. The
// remaining eight stages are a restoring divider that settles one quotient bit
// per stage for each of the three color lanes in parallel. Each stage holds
// its own valid bit and only stalls when the stage after it is full and
// stalled, so back-pressure on the output fills the bubbles first. When both
// alphas are zero all outputs are 0.
`include "assert_macros.svh"

module alpha_over_blend
    import aob_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // front_red, front_green, front_blue, front_alpha,
    // back_red, back_green, back_blue, back_alpha (8 bits each, lowest first)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // out_red, out_green, out_blue, out_alpha (8 bits each, lowest first)
    output logic [OUT_W-1:0] m_tdata
);

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES:0]   adv;

    // Input fields
    chan_t front_c [COLORS];
    chan_t back_c  [COLORS];
    chan_t front_alpha, back_alpha;

    // Stage 0: weights
    sum_t  wf_reg, wf_next;
    sum_t  wb_reg, wb_next;
    chan_t fc_reg [COLORS];
    chan_t bc_reg [COLORS];

    // Stage 1: products
    sum_t  sum_reg, sum_next;
    prod_t pf_reg [COLORS];
    prod_t pb_reg [COLORS];

    // Stage 2: S + (S >> 8) + 1, whose upper byte is S/255 for any S up to 255*255
    sum_t  alpha_acc;

    // Stages 2..STAGES-1: divider, index 0 holds the numerator
    num_t  rem_reg   [CH_W+1][COLORS];
    chan_t quot_reg  [CH_W+1][COLORS];
    sum_t  div_reg   [CH_W+1];
    chan_t alpha_reg [CH_W+1];

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    always_comb begin
        adv[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {alpha_reg[CH_W], quot_reg[CH_W][2],
                       quot_reg[CH_W][1], quot_reg[CH_W][0]};

    // ---------------------------------------------------------------
    // Stage 0: fa*255 and ba*(255-fa)
    // ---------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < COLORS; c++) begin
            front_c[c] = s_tdata[c*CH_W +: CH_W];
            back_c[c]  = s_tdata[(c+4)*CH_W +: CH_W];
        end
        front_alpha = s_tdata[3*CH_W +: CH_W];
        back_alpha  = s_tdata[7*CH_W +: CH_W];
        wf_next = {front_alpha, {CH_W{1'b0}}} - SUM_W'(front_alpha);
        wb_next = SUM_W'(back_alpha) * SUM_W'(CH_MAX - front_alpha);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            wf_reg <= wf_next;
            wb_reg <= wb_next;
            for (int c = 0; c < COLORS; c++) begin
                fc_reg[c] <= front_c[c];
                bc_reg[c] <= back_c[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: channel products and weight sum
    // ---------------------------------------------------------------
    assign sum_next = wf_reg + wb_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sum_reg <= sum_next;
            for (int c = 0; c < COLORS; c++) begin
                pf_reg[c] <= PROD_W'(fc_reg[c]) * PROD_W'(wf_reg);
                pb_reg[c] <= PROD_W'(bc_reg[c]) * PROD_W'(wb_reg);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: numerators and alpha; a zero sum divides by one so every
    // quotient is 0
    // ---------------------------------------------------------------
    assign alpha_acc = sum_reg + (sum_reg >> CH_W) + SUM_W'(1);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int c = 0; c < COLORS; c++) begin
                rem_reg[0][c]  <= NUM_W'(pf_reg[c]) + NUM_W'(pb_reg[c]);
                quot_reg[0][c] <= '0;
            end
            alpha_reg[0] <= alpha_acc[SUM_W-1:CH_W];
            div_reg[0]   <= (sum_reg == '0) ? ONE_DIV : sum_reg;
        end
    end

    // ---------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first
    // ---------------------------------------------------------------
    for (genvar j = 1; j <= CH_W; j++) begin : g_div
        localparam int BIT = CH_W - j;

        num_t  trial     [COLORS];
        logic  ge        [COLORS];
        num_t  rem_next  [COLORS];
        chan_t quot_next [COLORS];

        always_comb begin
            for (int l = 0; l < COLORS; l++) begin
                trial[l]     = NUM_W'(div_reg[j-1]) << BIT;
                ge[l]        = rem_reg[j-1][l] >= trial[l];
                rem_next[l]  = ge[l] ? (rem_reg[j-1][l] - trial[l]) : rem_reg[j-1][l];
                quot_next[l] = quot_reg[j-1][l];
                quot_next[l][BIT] = ge[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[2+j]) begin
                div_reg[j]   <= div_reg[j-1];
                alpha_reg[j] <= alpha_reg[j-1];
                for (int l = 0; l < COLORS; l++) begin
                    rem_reg[j][l]  <= rem_next[l];
                    quot_reg[j][l] <= quot_next[l];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    for (genvar l = 0; l < COLORS; l++) begin : g_chk
        `ASSERT_CLK(a_color_rem_below_div, aclk, aresetn,
                    m_tvalid |-> (rem_reg[CH_W][l] < NUM_W'(div_reg[CH_W])),
                    "color remainder not below divisor")
    end

    `ASSERT_CLK(a_stall_only_when_full, aclk, aresetn,
                !s_tready |-> (m_tvalid && !m_tready),
                "input stalled while output side can drain")
    `ASSERT_CLK(a_accept_enters_pipe, aclk, aresetn,
                (s_tvalid && s_tready) |=> valid_reg[0],
                "accepted beat missing from first stage")
    `ASSERT_CLK(a_hold_while_stalled, aclk, aresetn,
                (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
                "output beat changed while stalled")

endmodule
